// ===== hw/rtl/clock_tree_frequency_calculator_defines.svh =====
`ifndef CLOCK_TREE_FREQUENCY_CALCULATOR_DEFINES_SVH
`define CLOCK_TREE_FREQUENCY_CALCULATOR_DEFINES_SVH

// check a property on every rising clock edge outside reset
`define CTFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition leads to a consequence in the next cycle
`define CTFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ctfc_pkg.sv =====
package ctfc_pkg;

  localparam int unsigned OscWidth      = 25;
  localparam int unsigned FreqWidth     = 33;
  localparam int unsigned DividendWidth = 34;
  localparam int unsigned DivisorWidth  = 9;
  localparam int unsigned CntWidth      = $clog2(DividendWidth + 1);

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_SRC = 2'd1;
  localparam logic [1:0] STATUS_M_ZERO  = 2'd2;

  localparam logic [1:0] SRC_INTERNAL = 2'd0;
  localparam logic [1:0] SRC_EXTERNAL = 2'd1;
  localparam logic [1:0] SRC_PLL      = 2'd2;

  localparam logic CFG_INTERNAL_OSC = 1'b0;
  localparam logic CFG_EXTERNAL_OSC = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                     start;
    logic [DividendWidth-1:0] dividend;
    logic [DivisorWidth-1:0]  divisor;
  } div_req_t;

  function automatic logic [3:0] ahb_shift(input logic [3:0] code);
    logic [3:0] sh;
    unique case (code)
      4'd8:    sh = 4'd1;
      4'd9:    sh = 4'd2;
      4'd10:   sh = 4'd3;
      4'd11:   sh = 4'd4;
      4'd12:   sh = 4'd6;
      4'd13:   sh = 4'd7;
      4'd14:   sh = 4'd8;
      4'd15:   sh = 4'd9;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

  function automatic logic [2:0] apb_shift(input logic [2:0] code);
    logic [2:0] sh;
    unique case (code)
      3'd4:    sh = 3'd1;
      3'd5:    sh = 3'd2;
      3'd6:    sh = 3'd3;
      3'd7:    sh = 3'd4;
      default: sh = 3'd0;
    endcase
    return sh;
  endfunction

  function automatic logic [3:0] pll_p(input logic [1:0] code);
    logic [3:0] p;
    unique case (code)
      2'd0: p = 4'd2;
      2'd1: p = 4'd4;
      2'd2: p = 4'd6;
      2'd3: p = 4'd8;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/ctfc_divider.sv =====
module ctfc_divider
  import ctfc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  div_req_t                 req_i,
  output logic                     done_o,
  output logic [DividendWidth-1:0] quotient_o
);

  logic [DividendWidth-1:0] quo_q, quo_d;
  logic [DivisorWidth-1:0]  rem_q, rem_d;
  logic [DivisorWidth-1:0]  div_q;
  logic [CntWidth-1:0]      cnt_q, cnt_d;
  logic [DivisorWidth:0]    rem_sh;
  logic [DivisorWidth:0]    rem_sub;
  logic                     ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DividendWidth-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    ge      = rem_sh >= {1'b0, div_q};
    rem_d   = ge ? rem_sub[DivisorWidth-1:0] : rem_sh[DivisorWidth-1:0];
    quo_d   = {quo_q[DividendWidth-2:0], ge};
    cnt_d   = cnt_q - CntWidth'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= CntWidth'(DividendWidth);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = (cnt_q == '0);
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/clock_tree_frequency_calculator.sv =====
// A PLL-source transfer runs through ST_PREP, ST_DIV and ST_FINISH; an oscillator
// source or an error goes from ST_PREP straight to ST_FINISH, which waits while a
// pending output is stalled. No new item is taken until the last is loaded out.
// The PLL path uses the 34-step radix-2 divider that forms floor(src*N/(M*P)).
// Reset (rst_ni low, asynchronous): oscillator registers to 16 MHz and 8 MHz,
// kept frequencies to zero, no result pending.
`include "clock_tree_frequency_calculator_defines.svh"

module clock_tree_frequency_calculator
  import ctfc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [OscWidth-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           source_select_i,
  input  logic [3:0]           ahb_prescale_code_i,
  input  logic [2:0]           apb1_prescale_code_i,
  input  logic [2:0]           apb2_prescale_code_i,
  input  logic [5:0]           pll_divide_m_i,
  input  logic [8:0]           pll_multiply_n_i,
  input  logic [1:0]           pll_divide_p_code_i,
  input  logic                 pll_from_external_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [FreqWidth-1:0] ahb_hz_o,
  output logic [FreqWidth-1:0] apb1_hz_o,
  output logic [FreqWidth-1:0] apb2_hz_o
);

  state_e state_q, state_d;

  logic [OscWidth-1:0]  int_osc_q, ext_osc_q;
  logic [1:0]           src_q;
  logic [3:0]           ahb_code_q;
  logic [2:0]           apb1_code_q, apb2_code_q;
  logic [5:0]           m_q;
  logic [8:0]           n_q;
  logic [1:0]           p_code_q;
  logic                 pll_ext_q;
  logic [FreqWidth-1:0] sys_q, sys_d;
  logic                 load_sys;
  logic [1:0]           status_q, status_d;
  logic [1:0]           status_out_q;
  logic                 out_valid_q;
  logic [FreqWidth-1:0] last_ahb_q, last_apb1_q, last_apb2_q;
  logic [FreqWidth-1:0] ahb_new, apb1_new, apb2_new;
  logic                 in_xfer, out_load;
  logic [1:0]           prep_status;
  logic [OscWidth-1:0]  pll_in;
  logic [DividendWidth-1:0] product;
  logic [9:0]           mp_full;
  div_req_t             div_req;
  logic                 div_done;
  logic [DividendWidth-1:0] div_quo;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_osc_q <= OscWidth'(16000000);
      ext_osc_q <= OscWidth'(8000000);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_INTERNAL_OSC: int_osc_q <= cfg_data_i;
        CFG_EXTERNAL_OSC: ext_osc_q <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    pll_in  = pll_ext_q ? ext_osc_q : int_osc_q;
    product = {{(DividendWidth-OscWidth){1'b0}}, pll_in} *
              {{(DividendWidth-9){1'b0}}, n_q};
    mp_full = {4'b0, m_q} * {6'b0, pll_p(p_code_q)};
    priority if (src_q == SRC_PLL && m_q == '0) begin
      prep_status = STATUS_M_ZERO;
    end else if (src_q != SRC_INTERNAL && src_q != SRC_EXTERNAL && src_q != SRC_PLL) begin
      prep_status = STATUS_BAD_SRC;
    end else begin
      prep_status = STATUS_OK;
    end
  end

  ctfc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = product;
    div_req.divisor  = mp_full[DivisorWidth-1:0];
    load_sys         = 1'b0;
    sys_d            = div_quo[FreqWidth-1:0];
    status_d         = status_q;
    out_load         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_PREP;
      end
      ST_PREP: begin
        status_d = prep_status;
        if (prep_status != STATUS_OK) begin
          state_d = ST_FINISH;
        end else if (src_q == SRC_PLL) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end else begin
          load_sys = 1'b1;
          sys_d    = {{(FreqWidth-OscWidth){1'b0}},
                      (src_q == SRC_EXTERNAL) ? ext_osc_q : int_osc_q};
          state_d  = ST_FINISH;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          load_sys = 1'b1;
          state_d  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ahb_new  = sys_q >> ahb_shift(ahb_code_q);
    apb1_new = ahb_new >> apb_shift(apb1_code_q);
    apb2_new = ahb_new >> apb_shift(apb2_code_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      status_out_q <= STATUS_OK;
      last_ahb_q   <= '0;
      last_apb1_q  <= '0;
      last_apb2_q  <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        status_out_q <= status_q;
      end
      if (out_load && status_q == STATUS_OK) begin
        last_ahb_q  <= ahb_new;
        last_apb1_q <= apb1_new;
        last_apb2_q <= apb2_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      src_q       <= source_select_i;
      ahb_code_q  <= ahb_prescale_code_i;
      apb1_code_q <= apb1_prescale_code_i;
      apb2_code_q <= apb2_prescale_code_i;
      m_q         <= pll_divide_m_i;
      n_q         <= pll_multiply_n_i;
      p_code_q    <= pll_divide_p_code_i;
      pll_ext_q   <= pll_from_external_i;
    end
    if (load_sys) sys_q <= sys_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_out_q;
  assign ahb_hz_o    = last_ahb_q;
  assign apb1_hz_o   = last_apb1_q;
  assign apb2_hz_o   = last_apb2_q;

  `CTFC_ASSERT_NEXT(a_div_start_busy, div_req.start, !div_done, "divider idle after start")
  `CTFC_ASSERT_NEXT(a_err_keeps_state, out_load && status_q != STATUS_OK,
                    $stable(last_ahb_q) && $stable(last_apb1_q), "error result changed state")
  `CTFC_ASSERT_NEXT(a_pending_holds, out_valid_q && out_stall_i,
                    $stable(last_ahb_q) && $stable(status_out_q), "pending result overwritten")

endmodule

// ===== bench/tb.sv =====
module tb;
  import ctfc_pkg::*;

  localparam logic [1:0] SRC_INVALID = 2'd3;
  localparam logic [OscWidth-1:0] OSC_MAX = {OscWidth{1'b1}};

  typedef struct packed {
    logic [1:0] source_select;
    logic [3:0] ahb_code;
    logic [2:0] apb1_code;
    logic [2:0] apb2_code;
    logic [5:0] pll_m;
    logic [8:0] pll_n;
    logic [1:0] pll_p_code;
    logic       pll_ext;
  } readback_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [FreqWidth-1:0] ahb_hz;
    logic [FreqWidth-1:0] apb1_hz;
    logic [FreqWidth-1:0] apb2_hz;
  } bus_freqs_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = CFG_INTERNAL_OSC;
  logic [OscWidth-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           source_select = '0;
  logic [3:0]           ahb_prescale_code = '0;
  logic [2:0]           apb1_prescale_code = '0;
  logic [2:0]           apb2_prescale_code = '0;
  logic [5:0]           pll_divide_m = '0;
  logic [8:0]           pll_multiply_n = '0;
  logic [1:0]           pll_divide_p_code = '0;
  logic                 pll_from_external = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           status;
  logic [FreqWidth-1:0] ahb_hz;
  logic [FreqWidth-1:0] apb1_hz;
  logic [FreqWidth-1:0] apb2_hz;

  logic [OscWidth-1:0]      internal_hz;
  logic [OscWidth-1:0]      external_hz;
  logic [DividendWidth-1:0] kept_ahb_hz;
  logic [DividendWidth-1:0] kept_apb1_hz;
  logic [DividendWidth-1:0] kept_apb2_hz;

  bus_freqs_t pending_freqs[$];
  int unsigned errors = 0;
  bit in_idle_on = 1'b1;
  bit out_stall_on = 1'b1;
  int unsigned stall_run = 0;

  clock_tree_frequency_calculator dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .source_select_i      (source_select),
    .ahb_prescale_code_i  (ahb_prescale_code),
    .apb1_prescale_code_i (apb1_prescale_code),
    .apb2_prescale_code_i (apb2_prescale_code),
    .pll_divide_m_i       (pll_divide_m),
    .pll_multiply_n_i     (pll_multiply_n),
    .pll_divide_p_code_i  (pll_divide_p_code),
    .pll_from_external_i  (pll_from_external),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .status_o             (status),
    .ahb_hz_o             (ahb_hz),
    .apb1_hz_o            (apb1_hz),
    .apb2_hz_o            (apb2_hz)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned apb_divisor(input logic [2:0] code);
    case (code)
      3'd4:    return 2;
      3'd5:    return 4;
      3'd6:    return 8;
      3'd7:    return 16;
      default: return 1;
    endcase
  endfunction

  function automatic bus_freqs_t compute_bus_freqs(input readback_t rb);
    logic [63:0] sys_hz;
    logic [63:0] pll_in_hz;
    logic [63:0] bus_hz;
    int unsigned ahb_div;
    int unsigned p_div;
    bus_freqs_t f;
    f.status = STATUS_OK;
    sys_hz = '0;
    case (rb.source_select)
      SRC_INTERNAL: sys_hz = 64'(internal_hz);
      SRC_EXTERNAL: sys_hz = 64'(external_hz);
      SRC_PLL: begin
        if (rb.pll_m == 6'd0) begin
          f.status = STATUS_M_ZERO;
        end else begin
          pll_in_hz = rb.pll_ext ? 64'(external_hz) : 64'(internal_hz);
          case (rb.pll_p_code)
            2'd0:    p_div = 2;
            2'd1:    p_div = 4;
            2'd2:    p_div = 6;
            default: p_div = 8;
          endcase
          sys_hz = ((pll_in_hz * 64'(rb.pll_n)) / 64'(rb.pll_m)) / 64'(p_div);
        end
      end
      default: f.status = STATUS_BAD_SRC;
    endcase
    if (f.status == STATUS_OK) begin
      case (rb.ahb_code)
        4'd8:    ahb_div = 2;
        4'd9:    ahb_div = 4;
        4'd10:   ahb_div = 8;
        4'd11:   ahb_div = 16;
        4'd12:   ahb_div = 64;
        4'd13:   ahb_div = 128;
        4'd14:   ahb_div = 256;
        4'd15:   ahb_div = 512;
        default: ahb_div = 1;
      endcase
      bus_hz = sys_hz / 64'(ahb_div);
      kept_ahb_hz = bus_hz[DividendWidth-1:0];
      kept_apb1_hz = DividendWidth'(bus_hz / 64'(apb_divisor(rb.apb1_code)));
      kept_apb2_hz = DividendWidth'(bus_hz / 64'(apb_divisor(rb.apb2_code)));
    end
    f.ahb_hz = kept_ahb_hz[FreqWidth-1:0];
    f.apb1_hz = kept_apb1_hz[FreqWidth-1:0];
    f.apb2_hz = kept_apb2_hz[FreqWidth-1:0];
    return f;
  endfunction

  function automatic readback_t make_readback(input logic [1:0] src, input logic [3:0] ahb,
                                              input logic [2:0] apb1, input logic [2:0] apb2,
                                              input logic [5:0] m, input logic [8:0] n,
                                              input logic [1:0] p, input logic ext);
    readback_t rb;
    rb.source_select = src;
    rb.ahb_code = ahb;
    rb.apb1_code = apb1;
    rb.apb2_code = apb2;
    rb.pll_m = m;
    rb.pll_n = n;
    rb.pll_p_code = p;
    rb.pll_ext = ext;
    return rb;
  endfunction

  function automatic readback_t random_readback();
    readback_t rb;
    int unsigned r;
    rb = readback_t'({$urandom, $urandom});
    r = $urandom_range(0, 99);
    if (r < 20) begin
      rb.source_select = SRC_INTERNAL;
    end else if (r < 40) begin
      rb.source_select = SRC_EXTERNAL;
    end else if (r < 93) begin
      rb.source_select = SRC_PLL;
    end else begin
      rb.source_select = SRC_INVALID;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      rb.pll_m = 6'd0;
    end else if (r < 10) begin
      rb.pll_m = 6'd1;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      rb.pll_n = 9'd0;
    end else if (r < 10) begin
      rb.pll_n = 9'h1ff;
    end
    return rb;
  endfunction

  task automatic send_readback(input readback_t rb);
    int unsigned gap;
    gap = in_idle_on ? gap_length() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    source_select <= rb.source_select;
    ahb_prescale_code <= rb.ahb_code;
    apb1_prescale_code <= rb.apb1_code;
    apb2_prescale_code <= rb.apb2_code;
    pll_divide_m <= rb.pll_m;
    pll_multiply_n <= rb.pll_n;
    pll_divide_p_code <= rb.pll_p_code;
    pll_from_external <= rb.pll_ext;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    pending_freqs.push_back(compute_bus_freqs(rb));
  endtask

  task automatic wait_all_reported();
    in_valid <= 1'b0;
    while (pending_freqs.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_osc(input logic idx, input logic [OscWidth-1:0] hz);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= hz;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_INTERNAL_OSC) begin
      internal_hz = hz;
    end else begin
      external_hz = hz;
    end
  endtask

  task automatic check_field(input string name, input logic [FreqWidth-1:0] exp_val,
                             input logic [FreqWidth-1:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= out_stall_on && ($urandom_range(0, 2) == 0);
      stall_run <= gap_length();
    end
  end

  always @(posedge clk_i) begin
    bus_freqs_t exp_f;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_freqs.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, actual status %0d ahb %0d",
                 $time, status, ahb_hz);
      end else begin
        exp_f = pending_freqs.pop_front();
        check_field("status", FreqWidth'(exp_f.status), FreqWidth'(status));
        check_field("ahb_hz", exp_f.ahb_hz, ahb_hz);
        check_field("apb1_hz", exp_f.apb1_hz, apb1_hz);
        check_field("apb2_hz", exp_f.apb2_hz, apb2_hz);
      end
    end
  end

  task automatic test_reset_config();
    send_readback(make_readback(SRC_INVALID, 4'd0, 3'd0, 3'd0, 6'd8, 9'd336, 2'd1, 1'b0));
    send_readback(make_readback(SRC_PLL, 4'd0, 3'd0, 3'd0, 6'd0, 9'd336, 2'd1, 1'b0));
    send_readback(make_readback(SRC_INTERNAL, 4'd0, 3'd0, 3'd0, 6'd4, 9'd50, 2'd0, 1'b0));
    send_readback(make_readback(SRC_EXTERNAL, 4'd15, 3'd7, 3'd4, 6'd63, 9'd511, 2'd3, 1'b1));
    send_readback(make_readback(SRC_INTERNAL, 4'd7, 3'd3, 3'd7, 6'd0, 9'd0, 2'd0, 1'b0));
    send_readback(make_readback(SRC_EXTERNAL, 4'd8, 3'd4, 3'd5, 6'd0, 9'd1, 2'd2, 1'b1));
    send_readback(make_readback(SRC_PLL, 4'd0, 3'd0, 3'd0, 6'd1, 9'd511, 2'd0, 1'b0));
    send_readback(make_readback(SRC_PLL, 4'd0, 3'd6, 3'd7, 6'd63, 9'd0, 2'd3, 1'b1));
    send_readback(make_readback(SRC_PLL, 4'd12, 3'd5, 3'd4, 6'd8, 9'd336, 2'd1, 1'b0));
    send_readback(make_readback(SRC_PLL, 4'd13, 3'd5, 3'd6, 6'd4, 9'd100, 2'd2, 1'b1));
    send_readback(make_readback(SRC_INVALID, 4'd15, 3'd7, 3'd7, 6'd63, 9'd511, 2'd3, 1'b1));
    send_readback(make_readback(SRC_PLL, 4'd9, 3'd6, 3'd4, 6'd0, 9'd511, 2'd3, 1'b1));
    send_readback(make_readback(SRC_PLL, 4'd10, 3'd6, 3'd1, 6'd25, 9'd432, 2'd0, 1'b1));
    send_readback(make_readback(SRC_PLL, 4'd14, 3'd2, 3'd5, 6'd63, 9'd511, 2'd3, 1'b0));
    send_readback(make_readback(SRC_EXTERNAL, 4'd11, 3'd7, 3'd6, 6'd42, 9'd170, 2'd1, 1'b0));
    wait_all_reported();
  endtask

  task automatic test_register_extremes();
    write_osc(CFG_INTERNAL_OSC, OSC_MAX);
    write_osc(CFG_EXTERNAL_OSC, OSC_MAX);
    send_readback(make_readback(SRC_PLL, 4'd0, 3'd0, 3'd0, 6'd1, 9'd511, 2'd0, 1'b0));
    send_readback(make_readback(SRC_PLL, 4'd0, 3'd7, 3'd4, 6'd1, 9'd511, 2'd0, 1'b1));
    wait_all_reported();
    write_osc(CFG_INTERNAL_OSC, '0);
    write_osc(CFG_EXTERNAL_OSC, '0);
    send_readback(make_readback(SRC_INTERNAL, 4'd0, 3'd0, 3'd0, 6'd1, 9'd1, 2'd0, 1'b0));
    send_readback(make_readback(SRC_EXTERNAL, 4'd0, 3'd0, 3'd0, 6'd1, 9'd1, 2'd0, 1'b0));
    send_readback(make_readback(SRC_PLL, 4'd0, 3'd0, 3'd0, 6'd1, 9'd511, 2'd0, 1'b1));
    wait_all_reported();
    write_osc(CFG_INTERNAL_OSC, 25'd1);
    write_osc(CFG_EXTERNAL_OSC, 25'd1);
    send_readback(make_readback(SRC_PLL, 4'd0, 3'd0, 3'd0, 6'd1, 9'd511, 2'd0, 1'b1));
    send_readback(make_readback(SRC_PLL, 4'd0, 3'd0, 3'd0, 6'd63, 9'd511, 2'd3, 1'b0));
    wait_all_reported();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_osc(CFG_INTERNAL_OSC, 25'($urandom));
          write_osc(CFG_EXTERNAL_OSC, 25'($urandom));
        end
        1: begin
          write_osc(CFG_INTERNAL_OSC, OSC_MAX);
          write_osc(CFG_EXTERNAL_OSC, OSC_MAX - 25'($urandom_range(0, 1000)));
        end
        2: begin
          write_osc(CFG_INTERNAL_OSC, 25'($urandom_range(1, 1000)));
          write_osc(CFG_EXTERNAL_OSC, 25'($urandom_range(0, 1000)));
        end
        3: begin
          write_osc(CFG_INTERNAL_OSC, 25'($urandom));
          write_osc(CFG_EXTERNAL_OSC, 25'($urandom));
        end
        default: begin
          write_osc(CFG_INTERNAL_OSC, 25'd16000000);
          write_osc(CFG_EXTERNAL_OSC, 25'd8000000);
        end
      endcase
      in_idle_on = (phase != 2);
      out_stall_on = (phase != 2);
      for (int k = 0; k < 400; k++) begin
        send_readback(random_readback());
      end
      wait_all_reported();
    end
    in_idle_on = 1'b1;
    out_stall_on = 1'b1;
  endtask

  initial begin
    internal_hz = 25'd16000000;
    external_hz = 25'd8000000;
    kept_ahb_hz = '0;
    kept_apb1_hz = '0;
    kept_apb2_hz = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_register_extremes();
    test_random_phases();
    wait_all_reported();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #15000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
